### hw/rtl/per_source_flood_limiter_defines.svh
// ---------------------------------------------------------------------------
// per_source_flood_limiter_defines
// assertion macros for the flood limiter, empty for synthesis
// ---------------------------------------------------------------------------
`ifndef PER_SOURCE_FLOOD_LIMITER_DEFINES_SVH
`define PER_SOURCE_FLOOD_LIMITER_DEFINES_SVH

`ifndef SYNTHESIS
// same-cycle implication, checked on clk, off during rst
`define PSFL_ASSERT_IMPLY(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("psfl check failed");
// next-cycle implication
`define PSFL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("psfl check failed");
`else
`define PSFL_ASSERT_IMPLY(label, ante, cons)
`define PSFL_ASSERT_NEXT(label, ante, cons)
`endif

`endif

### hw/rtl/psfl_pkg.sv
// ---------------------------------------------------------------------------
// psfl_pkg
// shared types and constants of the per-source flood limiter
// ---------------------------------------------------------------------------
package psfl_pkg;

  // controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_UPDATE
  } state_t;

  // result cause codes
  typedef enum logic [1:0] {
    CAUSE_ALLOW   = 2'd0,
    CAUSE_PENALTY = 2'd1,
    CAUSE_FLOOD   = 2'd2
  } cause_t;

  // configuration register indexes
  localparam logic [1:0] CFG_THRESHOLD = 2'd0;
  localparam logic [1:0] CFG_WINDOW    = 2'd1;
  localparam logic [1:0] CFG_PENALTY   = 2'd2;

  // configuration reset values
  localparam logic [7:0]  THRESHOLD_RESET = 8'd5;
  localparam logic [15:0] WINDOW_RESET    = 16'd10;
  localparam logic [15:0] PENALTY_RESET   = 16'd60;

  localparam int COUNT_W = 9;
  localparam int TIME_W  = 32;

endpackage

### hw/rtl/per_source_flood_limiter.sv
// ---------------------------------------------------------------------------
// per_source_flood_limiter
// fixed-window message rate limiter with a penalty period, per source
// ---------------------------------------------------------------------------
// Each input beat carries a source key and a timestamp in seconds and gives
// exactly one result beat: blocked, its cause (allowed, still in penalty,
// flood detected now), the table slot used and whether an older source was
// evicted to make room. Per-source state (key, count, window start, penalty
// end) lives in one single-port synchronous table of TABLE_DEPTH entries.
// After acceptance the table is scanned one entry per cycle through its read
// port until the key matches or all occupied slots have been seen; then
// ST_UPDATE writes the entry back, waiting while a stalled result is held.
// One item is worked on at a time; a finished result sits in the output
// register, so the next item is taken while it waits. The table needs no
// clearing after reset: only occupied slots are read. Configuration is to
// be written while idle, not enforced by the block; cfg_ready is always high.

`include "per_source_flood_limiter_defines.svh"

module per_source_flood_limiter #(
  parameter int TABLE_DEPTH = 256,
  parameter int KEY_BITS    = 64
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] source_key,
  input  logic [31:0] now_seconds,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        blocked,
  output logic [1:0]  cause,
  output logic [7:0]  entry_index,
  output logic        evicted,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int CW    = psfl_pkg::COUNT_W;
  localparam int TW    = psfl_pkg::TIME_W;

  // one table row
  typedef struct packed {
    logic [KEY_BITS-1:0] key;
    logic [CW-1:0]       count;
    logic [TW-1:0]       wstart;
    logic [TW-1:0]       pend;
  } entry_t;

  // configuration registers
  logic [7:0]  burst_limit;
  logic [15:0] window_seconds;
  logic [15:0] penalty_seconds;

  // control
  psfl_pkg::state_t state, state_next;
  logic [CNT_W-1:0] occupied;
  logic [CNT_W-1:0] rd_addr;
  logic             cmp_valid;
  logic [IDX_W-1:0] cmp_idx;

  // item being worked on
  logic [KEY_BITS-1:0] key_q;
  logic [TW-1:0]       now_q;
  logic [IDX_W-1:0]    lru_slot;
  logic [TW-1:0]       lru_start;
  entry_t              cur;
  logic [IDX_W-1:0]    slot;
  logic                is_new;
  logic                evict_q;

  // table memory
  entry_t tbl_mem [TABLE_DEPTH];
  entry_t rd_q;
  entry_t wr_entry;

  // handshake and strobes
  logic in_accept;
  logic out_free;
  logic rd_issue;
  logic upd_fire;

  // scan decode
  logic scan_empty;
  logic hit;
  logic older;
  logic last;
  logic scan_done;

  // update datapath
  logic          in_pen;
  logic          expired;
  logic [TW-1:0] age;
  logic [CW-1:0] cnt_inc;
  logic          flood;
  logic [TW:0]   end_sum;
  logic [TW-1:0] end_sat;
  logic [IDX_W+7:0] slot_ext;

  assign cfg_ready = 1'b1;
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;

  // ---------------------------------------------------------------------
  // configuration
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      burst_limit     <= psfl_pkg::THRESHOLD_RESET;
      window_seconds  <= psfl_pkg::WINDOW_RESET;
      penalty_seconds <= psfl_pkg::PENALTY_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        psfl_pkg::CFG_THRESHOLD: burst_limit     <= cfg_data[7:0];
        psfl_pkg::CFG_WINDOW:    window_seconds  <= cfg_data;
        psfl_pkg::CFG_PENALTY:   penalty_seconds <= cfg_data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // scan decode: compare stage sees the row latched into rd_q the cycle earlier
  // ---------------------------------------------------------------------
  assign scan_empty = (occupied == '0);
  assign hit        = (rd_q.key == key_q);
  assign older      = (cmp_idx == '0) || (rd_q.wstart < lru_start);
  assign last       = (CNT_W'(cmp_idx) == occupied - CNT_W'(1));
  assign scan_done  = scan_empty || (cmp_valid && (hit || last));

  // ---------------------------------------------------------------------
  // state machine
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= psfl_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      psfl_pkg::ST_IDLE: begin
        if (in_accept) state_next = psfl_pkg::ST_SCAN;
      end
      psfl_pkg::ST_SCAN: begin
        if (scan_done) state_next = psfl_pkg::ST_UPDATE;
      end
      psfl_pkg::ST_UPDATE: begin
        if (out_free) state_next = psfl_pkg::ST_IDLE;
      end
      default: state_next = psfl_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = 1'b1;
    rd_issue = 1'b0;
    upd_fire = 1'b0;
    unique case (state)
      psfl_pkg::ST_IDLE:   in_stall = 1'b0;
      psfl_pkg::ST_SCAN:   rd_issue = (rd_addr < occupied);
      psfl_pkg::ST_UPDATE: upd_fire = out_free;
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // scan control and working registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      cmp_valid <= 1'b0;
    end else begin
      cmp_valid <= rd_issue && !scan_done;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      key_q   <= source_key[KEY_BITS-1:0];
      now_q   <= now_seconds;
      rd_addr <= '0;
    end else if (rd_issue) begin
      rd_addr <= rd_addr + CNT_W'(1);
    end
    if (rd_issue) begin
      cmp_idx <= rd_addr[IDX_W-1:0];
    end

    if (state == psfl_pkg::ST_SCAN) begin
      if (scan_empty) begin
        // empty table: first slot
        slot    <= '0;
        evict_q <= 1'b0;
        is_new  <= 1'b1;
        cur     <= '{key: key_q, count: '0, wstart: now_q, pend: '0};
      end else if (cmp_valid) begin
        if (hit) begin
          slot    <= cmp_idx;
          evict_q <= 1'b0;
          is_new  <= 1'b0;
          cur     <= rd_q;
        end else if (last) begin
          // miss: next free slot, or replace the oldest window start
          is_new <= 1'b1;
          cur    <= '{key: key_q, count: '0, wstart: now_q, pend: '0};
          if (occupied < CNT_W'(TABLE_DEPTH)) begin
            slot    <= occupied[IDX_W-1:0];
            evict_q <= 1'b0;
          end else begin
            slot    <= older ? cmp_idx : lru_slot;
            evict_q <= 1'b1;
          end
        end else if (older) begin
          lru_slot  <= cmp_idx;
          lru_start <= rd_q.wstart;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // update datapath
  // ---------------------------------------------------------------------
  assign in_pen  = (cur.pend > now_q);
  assign age     = now_q - cur.wstart;
  // time going backwards counts as not expired
  assign expired = (now_q > cur.wstart) && (age > TW'(window_seconds));
  assign cnt_inc = (expired ? CW'(0) : cur.count) + CW'(1);
  assign flood   = (cnt_inc > CW'(burst_limit));
  assign end_sum = {1'b0, now_q} + (TW + 1)'(penalty_seconds);
  assign end_sat = end_sum[TW] ? {TW{1'b1}} : end_sum[TW-1:0];

  always_comb begin
    wr_entry = cur;
    if (!in_pen) begin
      wr_entry.count  = flood ? CW'(0) : cnt_inc;
      wr_entry.wstart = expired ? now_q : cur.wstart;
      wr_entry.pend   = flood ? end_sat : cur.pend;
    end
  end

  // ---------------------------------------------------------------------
  // table memory: one read port in scan, one write in update
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (upd_fire) begin
      tbl_mem[slot] <= wr_entry;
    end
    if (rd_issue) begin
      rd_q <= tbl_mem[rd_addr[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      occupied <= '0;
    end else if (upd_fire && is_new && !evict_q) begin
      occupied <= occupied + CNT_W'(1);
    end
  end

  // ---------------------------------------------------------------------
  // result register
  // ---------------------------------------------------------------------
  assign slot_ext = (IDX_W + 8)'(slot);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (upd_fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_fire) begin
      blocked     <= in_pen || flood;
      cause       <= in_pen ? psfl_pkg::CAUSE_PENALTY :
                     (flood ? psfl_pkg::CAUSE_FLOOD : psfl_pkg::CAUSE_ALLOW);
      entry_index <= slot_ext[7:0];
      evicted     <= evict_q;
    end
  end

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  `PSFL_ASSERT_IMPLY(a_evict_full, out_valid && evicted, occupied == CNT_W'(TABLE_DEPTH))
  `PSFL_ASSERT_NEXT(a_accept_busy, in_accept, state != psfl_pkg::ST_IDLE)
  `PSFL_ASSERT_IMPLY(a_result_from_update, $rose(out_valid), $past(state) == psfl_pkg::ST_UPDATE)
  `PSFL_ASSERT_IMPLY(a_blocked_cause, out_valid, blocked == (cause != psfl_pkg::CAUSE_ALLOW))

endmodule

### tb/tb.sv
// ---------------------------------------------------------------------------
// tb
// regression for the per-source flood limiter
// ---------------------------------------------------------------------------
// Message beats go in with random gaps and result beats come out under
// random stalls. Every accepted message is judged by a model kept in this
// file, which holds its own copy of the source table and of the limits. Each
// result beat is checked field by field against the oldest pending verdict.
// A short directed part covers floods, penalties, key and time extremes,
// time going backwards, zero and maximum limits, penalty-end saturation and a
// write to an unused register index. Random traffic then runs under several
// limit settings, fills the table and forces evictions. One long receiver
// hold-off makes the block back up and stall its input.
`timescale 1ns / 1ps

module tb;

  localparam int TABLE_SLOTS = 256;
  localparam int COLD_KEYS = 320;
  localparam int HOT_KEYS = 6;
  localparam int LIMIT_CYCLES = 2000000;
  // index that maps to no register, the block must ignore it
  localparam logic [1:0] CFG_UNUSED = 2'd3;

  // one verdict per message
  typedef struct packed {
    logic             blocked;
    psfl_pkg::cause_t cause;
    logic [7:0]       entry_index;
    logic             evicted;
  } verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [63:0] source_key = '0;
  logic [31:0] now_seconds = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        blocked;
  logic [1:0]  cause;
  logic [7:0]  entry_index;
  logic        evicted;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  per_source_flood_limiter #(
    .TABLE_DEPTH(TABLE_SLOTS),
    .KEY_BITS   (64)
  ) dut (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .source_key (source_key),
    .now_seconds(now_seconds),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .blocked    (blocked),
    .cause      (cause),
    .entry_index(entry_index),
    .evicted    (evicted),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // limiter model: its own source table and limits
  // ---------------------------------------------------------------------------
  logic [63:0] src_key   [TABLE_SLOTS];
  logic [8:0]  src_count [TABLE_SLOTS];
  logic [31:0] src_start [TABLE_SLOTS];
  logic [31:0] src_pend  [TABLE_SLOTS];
  int          slots_used = 0;

  logic [7:0]  lim_threshold = psfl_pkg::THRESHOLD_RESET;
  logic [15:0] lim_window = psfl_pkg::WINDOW_RESET;
  logic [15:0] lim_penalty = psfl_pkg::PENALTY_RESET;

  verdict_t pending_verdicts[$];

  // stimulus knobs, shared with the idling processes
  int send_idle_pct = 13;
  int recv_idle_pct = 13;
  int hold_request = 0;
  int hold_left = 0;

  // bookkeeping
  int mismatch_count = 0;
  int messages_sent = 0;
  int results_seen = 0;
  int floods_seen = 0;
  int penalties_seen = 0;
  int evictions_seen = 0;
  int limit_settings = 1;
  int cycle_count = 0;

  logic [31:0] clock_s = '0;
  logic [63:0] cold_keys [COLD_KEYS];
  logic [63:0] hot_keys [HOT_KEYS];

  // judge one message and update the model's table
  function automatic verdict_t judge_message(input logic [63:0] key,
                                             input logic [31:0] now);
    verdict_t    v;
    int          slot;
    int          oldest_slot;
    logic [31:0] oldest_start;
    logic        hit;
    logic [32:0] end_time;
    v = '0;
    v.cause = psfl_pkg::CAUSE_ALLOW;
    slot = 0;
    oldest_slot = 0;
    oldest_start = '0;
    hit = 1'b0;
    // look up the key; on the way remember the oldest window, first one on ties
    for (int i = 0; i < slots_used && !hit; i++) begin
      if (src_key[i] == key) begin
        slot = i;
        hit = 1'b1;
      end else if (i == 0 || src_start[i] < oldest_start) begin
        oldest_start = src_start[i];
        oldest_slot = i;
      end
    end
    if (!hit) begin
      if (slots_used < TABLE_SLOTS) begin
        slot = slots_used;
        slots_used++;
      end else begin
        slot = oldest_slot;
        v.evicted = 1'b1;
      end
      src_key[slot] = key;
      src_count[slot] = '0;
      src_start[slot] = now;
      src_pend[slot] = '0;
    end
    if (src_pend[slot] > now) begin
      // still serving a penalty, message not counted
      v.blocked = 1'b1;
      v.cause = psfl_pkg::CAUSE_PENALTY;
    end else begin
      // window expired only when time moved strictly past it
      if (now > src_start[slot] && (now - src_start[slot]) > {16'd0, lim_window}) begin
        src_count[slot] = '0;
        src_start[slot] = now;
      end
      src_count[slot] = src_count[slot] + 9'd1;
      if (src_count[slot] > {1'b0, lim_threshold}) begin
        end_time = {1'b0, now} + {17'd0, lim_penalty};
        src_pend[slot] = end_time[32] ? 32'hFFFF_FFFF : end_time[31:0];
        src_count[slot] = '0;
        v.blocked = 1'b1;
        v.cause = psfl_pkg::CAUSE_FLOOD;
      end
    end
    v.entry_index = slot[7:0];
    return v;
  endfunction

  // ---------------------------------------------------------------------------
  // message sender: random gaps, then hold the beat until it is taken
  // ---------------------------------------------------------------------------
  task automatic send_message(input logic [63:0] key, input logic [31:0] now);
    int gap;
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      // mostly short gaps, now and then one that outlasts a full table scan
      gap = ($urandom_range(9) == 0) ? $urandom_range(300, 40) : $urandom_range(12, 1);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    source_key <= key;
    now_seconds <= now;
    do @(posedge clk); while (in_stall);
    pending_verdicts.push_back(judge_message(key, now));
    messages_sent++;
  endtask

  // let every pending verdict come back, block is idle afterwards
  task automatic drain;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write, model follows at the accepting edge
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      psfl_pkg::CFG_THRESHOLD: lim_threshold = value[7:0];
      psfl_pkg::CFG_WINDOW:    lim_window = value;
      psfl_pkg::CFG_PENALTY:   lim_penalty = value;
      default: begin
      end
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // drain, then load all three limits
  task automatic apply_limits(input logic [15:0] thr, input logic [15:0] win,
                              input logic [15:0] pen);
    drain();
    write_reg(psfl_pkg::CFG_THRESHOLD, thr);
    write_reg(psfl_pkg::CFG_WINDOW, win);
    write_reg(psfl_pkg::CFG_PENALTY, pen);
    limit_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // result side: random stalls plus an optional long hold-off
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // check each result beat against the oldest pending verdict
  always @(posedge clk) begin
    verdict_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (pending_verdicts.size() == 0) begin
        $display("%0t: result beat with no pending message (blocked %0b cause %0d slot %0d)",
                 $time, blocked, cause, entry_index);
        mismatch_count++;
      end else begin
        want = pending_verdicts.pop_front();
        if (blocked !== want.blocked) begin
          $display("%0t: blocked expected %0b actual %0b", $time, want.blocked, blocked);
          mismatch_count++;
        end
        if (cause !== want.cause) begin
          $display("%0t: cause expected %0d actual %0d", $time, want.cause, cause);
          mismatch_count++;
        end
        if (entry_index !== want.entry_index) begin
          $display("%0t: entry_index expected %0d actual %0d",
                   $time, want.entry_index, entry_index);
          mismatch_count++;
        end
        if (evicted !== want.evicted) begin
          $display("%0t: evicted expected %0b actual %0b", $time, want.evicted, evicted);
          mismatch_count++;
        end
        if (want.cause == psfl_pkg::CAUSE_FLOOD) floods_seen++;
        if (want.cause == psfl_pkg::CAUSE_PENALTY) penalties_seen++;
        if (want.evicted) evictions_seen++;
      end
    end
  end

  // run watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("%0t: run limit of %0d cycles hit, %0d verdicts still pending",
               $time, LIMIT_CYCLES, pending_verdicts.size());
      $display("per_source_flood_limiter regression: fail");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // reset limits: six messages in one second flood, the next is held off,
  // the penalty runs out exactly at its end second; key extremes too
  task automatic test_flood_and_penalty;
    repeat (6) send_message(64'h0, 32'd100);
    send_message(64'h0, 32'd101);
    send_message(64'h0, 32'd160);
    send_message(64'hFFFF_FFFF_FFFF_FFFF, 32'd200);
    send_message(64'h8000_0000_0000_0001, 32'd200);
  endtask

  // a stamp before the window start keeps the window open; an old stamp
  // still sees a penalty that ends later
  task automatic test_time_backwards;
    send_message(64'hFFFF_FFFF_FFFF_FFFF, 32'd150);
    send_message(64'h0, 32'd50);
  endtask

  // zero threshold, window and penalty: every counted beat floods, the
  // penalty ends in the same second and a one-second step expires the window
  task automatic test_zero_limits;
    apply_limits(16'd0, 16'd0, 16'd0);
    send_message(64'h0123_4567_89AB_CDEF, 32'd1000);
    send_message(64'h0123_4567_89AB_CDEF, 32'd1000);
    send_message(64'h0123_4567_89AB_CDEF, 32'd1001);
  endtask

  // penalty end pinned at the top of the time range
  task automatic test_time_saturation;
    apply_limits(16'd0, 16'hFFFF, 16'hFFFF);
    send_message(64'h5A5A_A5A5_0F0F_F0F0, 32'hFFFF_FFF0);
    send_message(64'h5A5A_A5A5_0F0F_F0F0, 32'hFFFF_FFFF);
    send_message(64'h5A5A_A5A5_0F0F_F0F0, 32'h0000_0000);
  endtask

  // top threshold from a full-width write, then an unused index that must
  // not touch any limit
  task automatic test_register_extremes;
    apply_limits(16'hFFFF, 16'd30, 16'd5);
    write_reg(CFG_UNUSED, 16'h0000);
    send_message(64'h1111_2222_3333_4444, 32'd5000);
    send_message(64'h1111_2222_3333_4444, 32'd5000);
  endtask

  // mixed traffic: bursts from a few busy sources, a wide pool of others
  // that fills the table and forces evictions, and brand new sources
  task automatic test_random_traffic(input int n_items, input int hot_used,
                                     input int hot_pct, input bit jumps);
    int          pick;
    int          step;
    int          cur_hot;
    logic [63:0] key;
    cur_hot = 0;
    repeat (n_items) begin
      pick = $urandom_range(99);
      if (pick < hot_pct) begin
        if ($urandom_range(3) == 0) cur_hot = $urandom_range(hot_used - 1);
        key = hot_keys[cur_hot];
      end else if (pick < hot_pct + (100 - hot_pct) * 2 / 3) begin
        key = cold_keys[$urandom_range(COLD_KEYS - 1)];
      end else begin
        key = {$urandom, $urandom};
      end
      // time mostly holds or creeps, sometimes leaps, rarely goes back or jumps anywhere
      step = $urandom_range(99);
      if (step >= 98) begin
        if (jumps) clock_s = $urandom;
      end else if (step >= 96) begin
        clock_s -= $urandom_range(50, 1);
      end else if (step >= 90) begin
        clock_s += $urandom_range(100, 10);
      end else if (step >= 60) begin
        clock_s += $urandom_range(3, 1);
      end
      send_message(key, clock_s);
    end
  endtask

  // receiver holds off long enough for the block to back up into its input
  task automatic test_backpressure;
    int i;
    apply_limits(16'd3, 16'd20, 16'd40);
    send_idle_pct = 0;
    hold_request = 1500;
    for (i = 0; i < 24; i++) send_message(hot_keys[i % 3], clock_s + i / 4);
    send_idle_pct = 13;
  endtask

  initial begin
    int i;
    for (i = 0; i < COLD_KEYS; i++) cold_keys[i] = {$urandom, $urandom};
    for (i = 0; i < HOT_KEYS; i++) hot_keys[i] = {$urandom, $urandom};

    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part, reset limits first
    test_flood_and_penalty();
    test_time_backwards();
    test_zero_limits();
    test_time_saturation();
    test_register_extremes();

    // random part: the top threshold needs one busy source, a long window
    // and a table with room, so it runs before the table fills
    clock_s = 32'd20000;
    apply_limits(16'h00FF, 16'hFFFF, 16'd0);
    test_random_traffic(300, 1, 90, 1'b0);
    apply_limits({8'd0, psfl_pkg::THRESHOLD_RESET}, psfl_pkg::WINDOW_RESET,
                 psfl_pkg::PENALTY_RESET);
    test_random_traffic(230, 6, 45, 1'b1);

    // long stretch with no idling on either side
    apply_limits({8'($urandom_range(255)), 8'($urandom_range(12, 1))},
                 16'($urandom_range(40, 2)), 16'($urandom_range(200, 1)));
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_traffic(180, 4, 50, 1'b1);
    send_idle_pct = 13;
    recv_idle_pct = 13;

    apply_limits(16'd0, 16'd0, 16'hFFFF);
    test_random_traffic(120, 6, 45, 1'b1);
    apply_limits({8'($urandom_range(255)), 8'($urandom_range(10, 1))},
                 16'($urandom_range(65535)), 16'($urandom_range(65535)));
    test_random_traffic(100, 6, 45, 1'b1);

    test_backpressure();

    // every verdict back, then a full scan worth of quiet for stray beats
    drain();
    repeat (TABLE_SLOTS + 8) @(posedge clk);
    if (pending_verdicts.size() != 0) begin
      $display("%0t: %0d verdicts never returned", $time, pending_verdicts.size());
      mismatch_count++;
    end

    $display("covered %0d messages under %0d limit settings, %0d result beats checked",
             messages_sent, limit_settings, results_seen);
    $display("saw %0d floods, %0d penalty blocks, %0d evictions, %0d mismatches",
             floods_seen, penalties_seen, evictions_seen, mismatch_count);
    if (mismatch_count == 0) begin
      $display("per_source_flood_limiter regression: pass");
    end else begin
      $display("per_source_flood_limiter regression: fail");
    end
    $finish;
  end

endmodule
